>>> hw/rtl/mvps_pkg.sv
// ----------------------------------------------------------------------------
// MPEG-4 VOP packet scanner package
// Shared item types, code constants and helpers for the packet scanner.
// ----------------------------------------------------------------------------
package mvps_pkg;

  localparam logic [7:0] VOP_CODE  = 8'hB6;
  localparam logic [7:0] USER_CODE = 8'hB2;
  localparam logic [7:0] P_CHAR    = 8'h70;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [23:0] START_PREFIX = 24'h000001;

  localparam logic [1:0] STATUS_NONE        = 2'd0;
  localparam logic [1:0] STATUS_MARKER_ONLY = 2'd1;
  localparam logic [1:0] STATUS_CONFIRMED   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       packet_end;
    logic       key_packet;
    logic       has_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [15:0] packet_vops;
    logic        packet_marker;
    logic [31:0] total_packets;
    logic [31:0] timed_packets;
    logic [31:0] key_packets;
    logic [31:0] timed_key_packets;
    logic [31:0] multi_vop_packets;
    logic [15:0] most_vops;
    logic [47:0] stream_bytes;
    logic        marker_seen;
    logic [1:0]  pack_state;
  } out_item_t;

  typedef struct packed {
    logic [15:0] vops;
    logic        marker;
  } scan_status_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

>>> hw/rtl/mvps_byte_scan.sv
// ----------------------------------------------------------------------------
// MPEG-4 VOP packet scanner: per-packet byte scan
// Tracks the last three bytes and the user-data window of the current packet
// and counts VOP start codes and flags the packed marker within it.
// ----------------------------------------------------------------------------
module mvps_byte_scan import mvps_pkg::*; #(
  parameter int USER_WINDOW = 255
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  in_item_t     item,
  input  logic         scan_enable,
  output scan_status_t status
);

  localparam int WIN_W = $clog2(USER_WINDOW + 1);
  localparam logic [WIN_W-1:0] WIN_LOAD = WIN_W'(USER_WINDOW);
  localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(1);

  logic [23:0]      byte_history, byte_history_next;
  logic [1:0]       history_fill, history_fill_next;
  logic [WIN_W-1:0] window_left, window_left_next;
  logic             prev_was_p, prev_was_p_next;
  logic [15:0]      vops_in_packet, vops_in_packet_next;
  logic             marker_in_packet, marker_in_packet_next;

  logic prefix;
  logic win_open;
  logic marker_hit;
  logic vop_hit;

  assign prefix   = (history_fill == 2'd3) && (byte_history == START_PREFIX);
  assign win_open = (window_left != '0);

  assign marker_hit = item.byte_valid && win_open && prev_was_p &&
                      (item.data_byte == ZERO_BYTE) && scan_enable;
  assign vop_hit    = item.byte_valid && prefix && (item.data_byte == VOP_CODE) &&
                      scan_enable && (vops_in_packet != 16'hFFFF);

  assign status.vops   = vops_in_packet + 16'(vop_hit);
  assign status.marker = marker_in_packet | marker_hit;

  always_comb begin
    byte_history_next     = byte_history;
    history_fill_next     = history_fill;
    window_left_next      = window_left;
    prev_was_p_next       = prev_was_p;
    vops_in_packet_next   = status.vops;
    marker_in_packet_next = status.marker;
    if (item.byte_valid) begin
      if (win_open) begin
        prev_was_p_next  = (item.data_byte == P_CHAR) && (window_left != WIN_LAST);
        window_left_next = window_left - WIN_LAST;
      end
      if (prefix && (item.data_byte == USER_CODE)) begin
        window_left_next = WIN_LOAD;
        prev_was_p_next  = 1'b0;
      end
      byte_history_next = {byte_history[15:0], item.data_byte};
      history_fill_next = (history_fill == 2'd3) ? history_fill : history_fill + 2'd1;
    end
    if (item.packet_end) begin
      byte_history_next     = '0;
      history_fill_next     = '0;
      window_left_next      = '0;
      prev_was_p_next       = 1'b0;
      vops_in_packet_next   = '0;
      marker_in_packet_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_history     <= '0;
      history_fill     <= '0;
      window_left      <= '0;
      prev_was_p       <= 1'b0;
      vops_in_packet   <= '0;
      marker_in_packet <= 1'b0;
    end else if (step) begin
      byte_history     <= byte_history_next;
      history_fill     <= history_fill_next;
      window_left      <= window_left_next;
      prev_was_p       <= prev_was_p_next;
      vops_in_packet   <= vops_in_packet_next;
      marker_in_packet <= marker_in_packet_next;
    end
  end

endmodule

>>> hw/rtl/mpeg4_vop_packet_scanner_top.sv
// ----------------------------------------------------------------------------
// MPEG-4 VOP packet scanner
// Counts VOP start codes and the packed user-data marker per packet and keeps
// saturating stream totals.
// ----------------------------------------------------------------------------
// One byte item is taken per cycle while the input side is not stalled. Each
// accepted item is held in an input register and then scanned in a single
// pass that updates the packet state and, on a packet end, loads the result
// register, so a packet result is offered once its last item has moved from
// the input register through the scan into the result register.
// The input side stalls only when a result is waiting in the result register
// and another packet end is ready to be scanned. Results are produced only
// for items with packet_end set; an item with byte_valid low and packet_end
// high closes an empty packet. The scan_enable register (reset 1) is written
// through the cfg channel and should change only while no transfer is in
// flight.
module mpeg4_vop_packet_scanner_top import mvps_pkg::*; #(
  parameter int USER_WINDOW = 255
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  in_item_t  src_item,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic         scan_enable;
  logic         s1_valid;
  in_item_t     s1_item;
  logic         s1_advance;
  scan_status_t scan_status;

  logic [31:0] packet_total, packet_total_next;
  logic [31:0] timed_total, timed_total_next;
  logic [31:0] key_total, key_total_next;
  logic [31:0] timed_key_total, timed_key_total_next;
  logic [31:0] multi_total, multi_total_next;
  logic [15:0] vop_peak, vop_peak_next;
  logic [47:0] byte_total, byte_total_next;
  logic        marker_any, marker_any_next;
  logic [1:0]  status_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_enable <= 1'b1;
    end else if (cfg_valid) begin
      scan_enable <= cfg_data;
    end
  end

  assign s1_advance = s1_valid && (!s1_item.packet_end || !res_valid || res_ready);
  assign src_ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_ready) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      s1_item <= src_item;
    end
  end

  mvps_byte_scan #(
    .USER_WINDOW(USER_WINDOW)
  ) u_byte_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_advance),
    .item       (s1_item),
    .scan_enable(scan_enable),
    .status     (scan_status)
  );

  always_comb begin
    packet_total_next    = packet_total;
    timed_total_next     = timed_total;
    key_total_next       = key_total;
    timed_key_total_next = timed_key_total;
    multi_total_next     = multi_total;
    vop_peak_next        = vop_peak;
    marker_any_next      = marker_any;
    byte_total_next      = byte_total;
    if (s1_item.byte_valid && (byte_total != 48'hFFFF_FFFF_FFFF)) begin
      byte_total_next = byte_total + 48'd1;
    end
    if (s1_item.packet_end) begin
      packet_total_next = sat_inc32(packet_total);
      if (s1_item.has_timestamp) begin
        timed_total_next = sat_inc32(timed_total);
      end
      if (s1_item.key_packet) begin
        key_total_next = sat_inc32(key_total);
        if (s1_item.has_timestamp) begin
          timed_key_total_next = sat_inc32(timed_key_total);
        end
      end
      if (scan_status.vops > 16'd1) begin
        multi_total_next = sat_inc32(multi_total);
      end
      if (scan_status.vops > vop_peak) begin
        vop_peak_next = scan_status.vops;
      end
      marker_any_next = marker_any | scan_status.marker;
    end
    if (multi_total_next != '0) begin
      status_next = STATUS_CONFIRMED;
    end else if (marker_any_next) begin
      status_next = STATUS_MARKER_ONLY;
    end else begin
      status_next = STATUS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_total    <= '0;
      timed_total     <= '0;
      key_total       <= '0;
      timed_key_total <= '0;
      multi_total     <= '0;
      vop_peak        <= '0;
      byte_total      <= '0;
      marker_any      <= 1'b0;
    end else if (s1_advance) begin
      packet_total    <= packet_total_next;
      timed_total     <= timed_total_next;
      key_total       <= key_total_next;
      timed_key_total <= timed_key_total_next;
      multi_total     <= multi_total_next;
      vop_peak        <= vop_peak_next;
      byte_total      <= byte_total_next;
      marker_any      <= marker_any_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance && s1_item.packet_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_item.packet_end) begin
      res_item.packet_vops       <= scan_status.vops;
      res_item.packet_marker     <= scan_status.marker;
      res_item.total_packets     <= packet_total_next;
      res_item.timed_packets     <= timed_total_next;
      res_item.key_packets       <= key_total_next;
      res_item.timed_key_packets <= timed_key_total_next;
      res_item.multi_vop_packets <= multi_total_next;
      res_item.most_vops         <= vop_peak_next;
      res_item.stream_bytes      <= byte_total_next;
      res_item.marker_seen       <= marker_any_next;
      res_item.pack_state        <= status_next;
    end
  end

  // A waiting result must never be overwritten by a new packet end.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !(s1_advance && s1_item.packet_end))
    else $error("result register overwritten while a transfer is pending");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.most_vops >= res_item.packet_vops)
    else $error("peak VOP count below packet VOP count");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.packet_marker |-> res_item.marker_seen)
    else $error("packet marker not reflected in marker_seen");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.multi_vop_packets != '0) |->
      res_item.pack_state == STATUS_CONFIRMED)
    else $error("packed status not confirmed after a multi-VOP packet");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.total_packets >= res_item.key_packets)
    else $error("key packet total exceeds packet total");

endmodule
